// File: rtl/ulp_pkg.sv
`default_nettype none
package ulp_pkg;

   localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
   localparam logic [15:0] IPV4_MIN_END    = 16'd34;
   localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
   localparam logic [15:0] PROBE_BYTES     = 16'd16;
   localparam logic [15:0] ETYPE_HI_POS    = 16'd12;
   localparam logic [15:0] ETYPE_LO_POS    = 16'd13;
   localparam logic [15:0] IHL_POS         = 16'd14;
   localparam logic [15:0] PROTO_POS       = 16'd23;
   localparam logic [15:0] LENGTH_MAX      = 16'hFFFF;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [31:0] NO_SEQUENCE     = 32'hFFFF_FFFF;
   localparam logic signed [63:0] LATENCY_FLOOR = -64'sd100000;

   // Byte offset of the UDP payload for a given IP header length in words.
   function automatic logic [15:0] payload_offset(input logic [3:0] ihl);
      payload_offset = ETH_HDR_BYTES + UDP_HDR_BYTES + {10'b0, ihl, 2'b00};
   endfunction

   // Frame summary handed from the byte parser to the result stage.
   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] frame_type;
      logic [7:0]  ip_protocol;
      logic [3:0]  ip_header_words;
      logic [31:0] sequence_number;
      logic [63:0] send_time_ns;
      logic [63:0] receive_time_ns;
   } frame_summary_type;

endpackage
`default_nettype wire

// File: rtl/ulp_frame_parse.sv
`default_nettype none
module ulp_frame_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_byte,
   input  wire logic [63:0]                 req_receive_time_ns,
   output logic                             summary_valid,
   output ulp_pkg::frame_summary_type       summary,
   input  wire logic                        summary_take
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [31:0] seq_ff, seq_in;
   logic [63:0] send_ff, send_in;
   logic        summary_valid_ff;
   ulp_pkg::frame_summary_type summary_ff, summary_in;

   logic        accept;
   logic [15:0] poff;
   logic [15:0] k;
   logic        in_probe;

   assign req_stall = summary_valid_ff && !summary_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      etype_in = etype_ff;
      proto_in = proto_ff;
      ihl_in   = ihl_ff;
      seq_in   = seq_ff;
      send_in  = send_ff;

      // The offset uses the header length as it stood before this byte.
      poff     = ulp_pkg::payload_offset(ihl_ff);
      k        = pos_ff - poff;
      in_probe = (pos_ff >= poff) && (k < ulp_pkg::PROBE_BYTES);

      if (pos_ff == ulp_pkg::ETYPE_HI_POS) begin
         etype_in[15:8] = req_data_byte;
      end else if (pos_ff == ulp_pkg::ETYPE_LO_POS) begin
         etype_in[7:0] = req_data_byte;
      end else if (pos_ff == ulp_pkg::IHL_POS) begin
         ihl_in = req_data_byte[3:0];
      end else if (pos_ff == ulp_pkg::PROTO_POS) begin
         proto_in = req_data_byte;
      end

      // Probe bytes 4 to 7 are the spare word and are not kept.
      if (in_probe) begin
         if (k[3]) begin
            send_in[k[2:0]*8 +: 8] = req_data_byte;
         end else if (!k[2]) begin
            seq_in[k[1:0]*8 +: 8] = req_data_byte;
         end
      end

      pos_in = (pos_ff == ulp_pkg::LENGTH_MAX) ? pos_ff : pos_ff + 16'd1;

      summary_in.frame_length    = pos_in;
      summary_in.frame_type      = etype_in;
      summary_in.ip_protocol     = proto_in;
      summary_in.ip_header_words = ihl_in;
      summary_in.sequence_number = seq_in;
      summary_in.send_time_ns    = send_in;
      summary_in.receive_time_ns = req_receive_time_ns;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         etype_ff         <= '0;
         proto_ff         <= '0;
         ihl_ff           <= '0;
         seq_ff           <= '0;
         send_ff          <= '0;
         summary_valid_ff <= 1'b0;
      end else begin
         if (accept && req_last_byte) begin
            pos_ff           <= '0;
            etype_ff         <= '0;
            proto_ff         <= '0;
            ihl_ff           <= '0;
            seq_ff           <= '0;
            send_ff          <= '0;
            summary_valid_ff <= 1'b1;
         end else begin
            if (accept) begin
               pos_ff   <= pos_in;
               etype_ff <= etype_in;
               proto_ff <= proto_in;
               ihl_ff   <= ihl_in;
               seq_ff   <= seq_in;
               send_ff  <= send_in;
            end
            if (summary_take) begin
               summary_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         summary_ff <= summary_in;
      end
   end

   assign summary_valid = summary_valid_ff;
   assign summary       = summary_ff;

endmodule
`default_nettype wire

// File: rtl/ulp_result.sv
`default_nettype none
module ulp_result (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        summary_valid,
   input  wire ulp_pkg::frame_summary_type  summary,
   output logic                             summary_take,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [15:0]                      rsp_frame_length,
   output logic [15:0]                      rsp_payload_bytes,
   output logic                             rsp_probe_found,
   output logic [31:0]                      rsp_sequence_number,
   output logic                             rsp_latency_valid,
   output logic signed [63:0]               rsp_latency_ns
);

   logic        valid_ff;
   logic [15:0] length_ff;
   logic [15:0] pay_ff, pay_in;
   logic        probe_ff, probe_in;
   logic [31:0] seq_ff, seq_in;
   logic        lvalid_ff, lvalid_in;
   logic signed [63:0] lat_ff, lat_in;

   logic [15:0] poff;
   logic        udp_ok;
   logic signed [63:0] diff;

   assign summary_take = summary_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      poff   = ulp_pkg::payload_offset(summary.ip_header_words);
      udp_ok = (summary.frame_length >= ulp_pkg::ETH_HDR_BYTES)
            && (summary.frame_type == ulp_pkg::ETHERTYPE_IPV4)
            && (summary.frame_length >= ulp_pkg::IPV4_MIN_END)
            && (summary.ip_protocol == ulp_pkg::PROTO_UDP)
            && (summary.frame_length >= poff);
      pay_in   = udp_ok ? summary.frame_length - poff : 16'd0;
      probe_in = pay_in >= ulp_pkg::PROBE_BYTES;
      seq_in   = probe_in ? summary.sequence_number : ulp_pkg::NO_SEQUENCE;

      // The difference wraps and is then read as a signed value.
      diff      = $signed(summary.receive_time_ns - summary.send_time_ns);
      lvalid_in = probe_in && (summary.send_time_ns != 64'd0)
               && (diff >= ulp_pkg::LATENCY_FLOOR);
      lat_in    = lvalid_in ? diff : 64'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (summary_take) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (summary_take) begin
         length_ff <= summary.frame_length;
         pay_ff    <= pay_in;
         probe_ff  <= probe_in;
         seq_ff    <= seq_in;
         lvalid_ff <= lvalid_in;
         lat_ff    <= lat_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_frame_length    = length_ff;
   assign rsp_payload_bytes   = pay_ff;
   assign rsp_probe_found     = probe_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_latency_valid   = lvalid_ff;
   assign rsp_latency_ns      = lat_ff;

endmodule
`default_nettype wire

// File: rtl/udp_latency_probe_parser.sv
// Parses an Ethernet frame presented one byte per transfer and reports one
// result per frame: frame length, UDP payload length, probe sequence number and
// the signed latency between the little-endian send time carried in the probe and
// the receive time sampled with the last byte. The block takes one byte every
// clock cycle while the request side is not stalled, with no gaps between frames;
// the result for a frame passes through a frame summary register and then the
// result register, so the next frame's bytes flow in while a result waits.
// Stall on the request side rises only when both registers hold unread results.
`default_nettype none
module udp_latency_probe_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_byte,
   input  wire logic [63:0]        req_receive_time_ns,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_frame_length,
   output logic [15:0]             rsp_payload_bytes,
   output logic                    rsp_probe_found,
   output logic [31:0]             rsp_sequence_number,
   output logic                    rsp_latency_valid,
   output logic signed [63:0]      rsp_latency_ns
);

   logic                       summary_valid;
   logic                       summary_take;
   ulp_pkg::frame_summary_type summary;

   ulp_frame_parse u_parse (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_receive_time_ns (req_receive_time_ns),
      .summary_valid       (summary_valid),
      .summary             (summary),
      .summary_take        (summary_take)
   );

   ulp_result u_result (
      .clock               (clock),
      .reset               (reset),
      .summary_valid       (summary_valid),
      .summary             (summary),
      .summary_take        (summary_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_payload_bytes   (rsp_payload_bytes),
      .rsp_probe_found     (rsp_probe_found),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_latency_valid   (rsp_latency_valid),
      .rsp_latency_ns      (rsp_latency_ns)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic [15:0] frame_length;
   logic [15:0] payload_bytes;
   logic        probe_found;
   logic [31:0] sequence_number;
   logic        latency_valid;
   logic [63:0] latency_ns;
} probe_result_type;

typedef logic [7:0] frame_bytes_type [$];

class frame_scoreboard;
   probe_result_type pending_results [$];
   int errors;
   int results_seen;

   // Per-frame parser state, cleared after every last byte.
   logic [15:0] frame_pos;
   logic [15:0] seen_frame_type;
   logic [7:0]  seen_protocol;
   logic [3:0]  header_words;
   logic [63:0] probe_word [2];

   function new();
      errors = 0;
      results_seen = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      frame_pos = '0;
      seen_frame_type = '0;
      seen_protocol = '0;
      header_words = '0;
      probe_word[0] = '0;
      probe_word[1] = '0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function int unsigned udp_payload_start(logic [3:0] words);
      return ulp_pkg::ETH_HDR_BYTES + ulp_pkg::UDP_HDR_BYTES + 4 * words;
   endfunction

   function void note_byte(logic [7:0] data, logic last, logic [63:0] rx_time);
      int unsigned idx;
      int unsigned start;
      int unsigned k;
      int unsigned len;
      int unsigned pay;
      logic [63:0] diff;
      probe_result_type r;
      idx = 32'(frame_pos);
      start = udp_payload_start(header_words);
      if (idx == ulp_pkg::ETYPE_HI_POS) seen_frame_type[15:8] = data;
      else if (idx == ulp_pkg::ETYPE_LO_POS) seen_frame_type[7:0] = data;
      else if (idx == ulp_pkg::IHL_POS) header_words = data[3:0];
      else if (idx == ulp_pkg::PROTO_POS) seen_protocol = data;
      // The payload start uses the header length known before this byte.
      if (idx >= start && idx < start + ulp_pkg::PROBE_BYTES) begin
         k = idx - start;
         probe_word[k / 8][(k % 8) * 8 +: 8] = data;
      end
      if (frame_pos != ulp_pkg::LENGTH_MAX) frame_pos++;
      if (!last) return;

      len = 32'(frame_pos);
      start = udp_payload_start(header_words);
      pay = 0;
      if (len >= ulp_pkg::IPV4_MIN_END && seen_frame_type == ulp_pkg::ETHERTYPE_IPV4 &&
          seen_protocol == ulp_pkg::PROTO_UDP && len >= start)
         pay = len - start;
      r.frame_length = 16'(len);
      r.payload_bytes = 16'(pay);
      r.probe_found = (pay >= ulp_pkg::PROBE_BYTES);
      r.sequence_number = ulp_pkg::NO_SEQUENCE;
      r.latency_valid = 1'b0;
      r.latency_ns = 64'd0;
      if (r.probe_found) begin
         r.sequence_number = probe_word[0][31:0];
         diff = rx_time - probe_word[1];
         if (probe_word[1] != 64'd0 && $signed(diff) >= ulp_pkg::LATENCY_FLOOR) begin
            r.latency_valid = 1'b1;
            r.latency_ns = diff;
         end
      end
      pending_results.push_back(r);
      clear_frame();
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 100)
         $display("result %0d: %s mismatch, got %h, expected %h", results_seen, what, got,
                  want);
   endtask

   task check_result(probe_result_type got);
      probe_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected transfer", 64'(got.frame_length), 64'd0);
         return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (got.frame_length !== want.frame_length)
         report_mismatch("frame_length", 64'(got.frame_length), 64'(want.frame_length));
      if (got.payload_bytes !== want.payload_bytes)
         report_mismatch("payload_bytes", 64'(got.payload_bytes), 64'(want.payload_bytes));
      if (got.probe_found !== want.probe_found)
         report_mismatch("probe_found", 64'(got.probe_found), 64'(want.probe_found));
      if (got.sequence_number !== want.sequence_number)
         report_mismatch("sequence_number", 64'(got.sequence_number),
                         64'(want.sequence_number));
      if (got.latency_valid !== want.latency_valid)
         report_mismatch("latency_valid", 64'(got.latency_valid), 64'(want.latency_valid));
      if (got.latency_ns !== want.latency_ns)
         report_mismatch("latency_ns", got.latency_ns, want.latency_ns);
   endtask
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic [63:0] req_receive_time_ns = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_payload_bytes;
   logic        rsp_probe_found;
   logic [31:0] rsp_sequence_number;
   logic        rsp_latency_valid;
   logic signed [63:0] rsp_latency_ns;

   frame_scoreboard board;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   bit hold_on = 1'b0;

   udp_latency_probe_parser DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .req_receive_time_ns(req_receive_time_ns),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_length(rsp_frame_length),
      .rsp_payload_bytes(rsp_payload_bytes),
      .rsp_probe_found(rsp_probe_found),
      .rsp_sequence_number(rsp_sequence_number),
      .rsp_latency_valid(rsp_latency_valid),
      .rsp_latency_ns(rsp_latency_ns)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : result_monitor
      probe_result_type got;
      got.frame_length = rsp_frame_length;
      got.payload_bytes = rsp_payload_bytes;
      got.probe_found = rsp_probe_found;
      got.sequence_number = rsp_sequence_number;
      got.latency_valid = rsp_latency_valid;
      got.latency_ns = rsp_latency_ns;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) board.check_result(got);
   end

   // Header fields win over probe bytes where a small header length makes them overlap.
   function automatic frame_bytes_type build_frame(int len, logic [3:0] ihl,
                                                   logic [15:0] etype, logic [7:0] proto,
                                                   logic [31:0] seq,
                                                   logic [63:0] send_time);
      frame_bytes_type f;
      int start;
      logic [127:0] probe;
      logic [7:0] b;
      start = 22 + 4 * ihl;
      probe = {send_time, 32'($urandom), seq};
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == 12) b = etype[15:8];
         else if (i == 13) b = etype[7:0];
         else if (i == 14) b = {b[7:4], ihl};
         else if (i == 23) b = proto;
         else if (i >= start && i < start + 16) b = probe[(i - start) * 8 +: 8];
         f.push_back(b);
      end
      return f;
   endfunction

   task automatic send_byte(logic [7:0] data, logic last, logic [63:0] rx_time, int idle);
      while ($urandom_range(99) < idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      req_receive_time_ns <= rx_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(data, last, rx_time);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(frame_bytes_type f, logic [63:0] rx_time);
      int idle;
      bit last;
      // Some frames go out back to back even in an idling phase.
      idle = ($urandom_range(4) == 0) ? 0 : send_idle_pct;
      for (int i = 0; i < f.size(); i++) begin
         last = (i == f.size() - 1);
         send_byte(f[i], last, last ? rx_time : {$urandom, $urandom}, idle);
      end
   endtask

   task automatic send_udp(int len, logic [3:0] ihl, logic [63:0] send_time,
                           logic [63:0] rx_time);
      send_frame(build_frame(len, ihl, ulp_pkg::ETHERTYPE_IPV4, ulp_pkg::PROTO_UDP,
                             $urandom, send_time), rx_time);
   endtask

   task automatic send_random_frame();
      int kind;
      int ihl;
      int pay;
      int len;
      logic [15:0] etype;
      logic [7:0] proto;
      logic [63:0] send_time;
      logic [63:0] rx_time;
      kind = $urandom_range(99);
      ihl = ($urandom_range(6) == 0) ? $urandom_range(15) : 5;
      pay = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(40, 16);
      len = 22 + 4 * ihl + pay;
      etype = ulp_pkg::ETHERTYPE_IPV4;
      proto = ulp_pkg::PROTO_UDP;
      // Mostly well-formed probes; the rest carry a wrong type, a wrong protocol or
      // are cut short.
      if (kind >= 91) len = $urandom_range(40, 1);
      else if (kind >= 83) proto = 8'($urandom);
      else if (kind >= 75) etype = 16'($urandom);
      send_time = ($urandom_range(9) == 0) ? 64'd0 : {$urandom, $urandom};
      case ($urandom_range(4))
         0: rx_time = {$urandom, $urandom};
         1: rx_time = send_time - 64'd100001 + 64'($urandom_range(2));
         default: rx_time = send_time + 64'($urandom_range(2_000_000)) - 64'd200000;
      endcase
      send_frame(build_frame(len, 4'(ihl), etype, proto, $urandom, send_time), rx_time);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic hold_receiver(int cycles);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_on = 1'b0;
   endtask

   task automatic run_phase(int idle, int stall, int min_bytes, int min_results);
      int first_byte;
      int first_result;
      send_idle_pct = idle;
      stall_pct = stall;
      first_byte = bytes_sent;
      first_result = board.results_seen;
      while (bytes_sent - first_byte < min_bytes ||
             board.results_seen - first_result < min_results)
         send_random_frame();
      wait_drained();
   endtask

   task automatic send_directed();
      logic [63:0] base;
      base = 64'd5_000_000;
      send_udp(1, 4'd5, base, base);
      send_udp(13, 4'd5, base, base);
      send_udp(14, 4'd5, base, base);
      send_udp(33, 4'd5, base, base);
      send_udp(42, 4'd5, base, base);
      send_udp(57, 4'd5, base, base);
      send_udp(58, 4'd5, 64'd1000, 64'd500000);
      // Header length zero puts the probe over the protocol byte.
      send_udp(38, 4'd0, base, base + 64'd77);
      send_udp(81, 4'd15, base, base);
      send_udp(98, 4'd15, base, base + 64'd12345);
      send_frame(build_frame(38, 4'd0, 16'h86DD, ulp_pkg::PROTO_UDP, 32'd7, base), base);
      send_frame(build_frame(38, 4'd0, ulp_pkg::ETHERTYPE_IPV4, 8'd6, 32'd7, base), base);
      send_udp(38, 4'd0, 64'd0, base);
      send_udp(38, 4'd0, base, base - 64'd100000);
      send_udp(38, 4'd0, base, base - 64'd100001);
      send_udp(38, 4'd0, 64'd1, 64'h8000_0000_0000_0000);
      send_udp(38, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      send_udp(38, 4'd0, 64'd1, 64'd0);
      send_frame(build_frame(38, 4'd0, ulp_pkg::ETHERTYPE_IPV4, ulp_pkg::PROTO_UDP,
                             32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), 64'hFFFF_FFFF_FFFF_FFFF);
      send_frame(build_frame(38, 4'd0, ulp_pkg::ETHERTYPE_IPV4, ulp_pkg::PROTO_UDP,
                             32'd0, 64'h0000_0000_0000_0100), 64'd0);
      wait_drained();
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_directed();
      run_phase(0, 0, 70, 1);
      run_phase(51, 0, 70, 1);
      run_phase(0, 51, 70, 1);
      run_phase(6, 6, 70, 1);

      // The receiver holds off while frames keep coming, so both result registers
      // fill and the input side has to stall.
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         hold_receiver(200);
         begin
            repeat (6) send_udp(40, 4'd0, 64'd3000, 64'd90000);
            req_valid <= 1'b0;
         end
      join
      wait_drained();

      if (board.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule
